// ----- src/ihc_pkg.sv -----
package ihc_pkg;

  localparam int unsigned MinHeaderBytes = 20;

  localparam logic [31:0] LocalAddrReset = 32'h0A2A_0002;
  localparam logic [3:0]  IpVersion4     = 4'd4;
  localparam logic [15:0] FragMask       = 16'h3FFF;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  ProtoUdp       = 8'd17;

  localparam logic [5:0] OffVersionIhl = 6'd0;
  localparam logic [5:0] OffTotalHi    = 6'd2;
  localparam logic [5:0] OffTotalLo    = 6'd3;
  localparam logic [5:0] OffFragHi     = 6'd6;
  localparam logic [5:0] OffFragLo     = 6'd7;
  localparam logic [5:0] OffProtocol   = 6'd9;
  localparam logic [5:0] OffDstFirst   = 6'd16;
  localparam logic [5:0] OffDstLast    = 6'd19;

  typedef enum logic [2:0] {
    VerdictIcmp      = 3'd0,
    VerdictUdp       = 3'd1,
    VerdictBadHeader = 3'd2,
    VerdictBadCsum   = 3'd3,
    VerdictNotOurs   = 3'd4,
    VerdictNoHandler = 3'd5
  } verdict_e;

  // summary of one finished frame, handed from front to back
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  version_ihl;
    logic [15:0] total_len;
    logic        frag_hit;
    logic        addr_match;
    logic [7:0]  protocol;
    logic [16:0] sum;
  } frame_rec_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic [31:0] verdict_count;
    logic [31:0] seen_count;
  } result_t;

endpackage

// ----- src/ipv4_header_checker.sv -----
// channel  | dir | handshake             | payload
// s_axis   | in  | tvalid/tready         | tdata[7:0] data_byte, tlast frame_end
// m_axis   | out | tvalid/tready         | tuser verdict, tdata result fields
// cfg      | in  | cfg_we_i              | cfg_wdata_i local_address
//
// One byte per cycle in, one verdict per frame out, registered in the queue and
// then in the output register. The front parses bytes into a frame summary that
// a small queue hands to the back, which decides the verdict and bumps counters
// into the output register. The input stalls only while the queue is full; the
// output register frees whenever its transaction is taken. Reset clears the parse
// state, the queue pointers, the counters and the output valid.
module ipv4_header_checker #(
  parameter int unsigned LINK_HEADER_BYTES = 14,
  parameter int unsigned COUNTER_BITS      = 32,
  parameter int unsigned QUEUE_DEPTH       = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] protocol, [13:8] header_length, [29:14] payload_length,
  // [61:30] verdict_count, [93:62] seen_count, [95:94] zero
  output logic [95:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // [2:0] verdict
);

  ihc_pkg::frame_rec_t rec_in, rec_out;
  ihc_pkg::result_t    res;
  logic                push, full, rec_valid, pop, accept;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  ihc_front #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_en_i  (accept),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  ihc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(rec_valid),
    .data_o (rec_out)
  );

  ihc_back #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(rec_valid),
    .rec_i      (rec_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tuser = res.verdict;
  assign m_axis_tdata = {2'b00, res.seen_count, res.verdict_count, res.payload_length,
                         res.header_length, res.protocol};

endmodule

// ----- src/ihc_front.sv -----
module ihc_front #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                byte_en_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                push_o,
  output ihc_pkg::frame_rec_t rec_o
);

  localparam logic [15:0] LinkBytes = 16'(LINK_HEADER_BYTES);

  logic [31:0] local_addr_q;
  logic [15:0] pos_q, pos_d;
  logic [16:0] sum_q, sum_d;
  logic [7:0]  vihl_q, vihl_d;
  logic [15:0] total_q, total_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic        match_q, match_d;
  logic [7:0]  hold_q, hold_d;

  logic        advance;
  logic [15:0] offset;
  logic        in_hdr;
  logic [5:0]  o6;
  logic [5:0]  ihl;
  logic [7:0]  want;
  logic [17:0] sum_add;

  always_comb begin
    advance = (pos_q != 16'hFFFF);
    pos_d   = advance ? pos_q + 16'd1 : pos_q;
    offset  = pos_q - LinkBytes;
    in_hdr  = advance && (pos_q >= LinkBytes) && (offset < 16'd64);
    o6      = offset[5:0];

    vihl_d  = vihl_q;
    total_d = total_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    match_d = match_q;
    hold_d  = hold_q;
    sum_d   = sum_q;

    unique case (o6[1:0])
      2'd0:    want = local_addr_q[31:24];
      2'd1:    want = local_addr_q[23:16];
      2'd2:    want = local_addr_q[15:8];
      default: want = local_addr_q[7:0];
    endcase

    if (in_hdr) begin
      unique case (o6)
        ihc_pkg::OffVersionIhl: vihl_d = byte_i;
        ihc_pkg::OffTotalHi:    total_d = {byte_i, total_q[7:0]};
        ihc_pkg::OffTotalLo:    total_d = {total_q[15:8], byte_i};
        ihc_pkg::OffFragHi:     frag_d = {byte_i, frag_q[7:0]};
        ihc_pkg::OffFragLo:     frag_d = {frag_q[15:8], byte_i};
        ihc_pkg::OffProtocol:   proto_d = byte_i;
        default: begin
          if (o6 >= ihc_pkg::OffDstFirst && o6 <= ihc_pkg::OffDstLast && byte_i != want) begin
            match_d = 1'b0;
          end
        end
      endcase
    end

    ihl     = {vihl_d[3:0], 2'b00};
    sum_add = {1'b0, sum_q} + {2'b00, hold_q, byte_i};
    if (in_hdr && o6 < ihl) begin
      if (!o6[0]) begin
        hold_d = byte_i;
      end else begin
        sum_d = 17'(sum_add[15:0]) + 17'(sum_add[17:16]);
      end
    end

    rec_o.len         = pos_d;
    rec_o.version_ihl = vihl_d;
    rec_o.total_len   = total_d;
    rec_o.frag_hit    = |(frag_d & ihc_pkg::FragMask);
    rec_o.addr_match  = match_d;
    rec_o.protocol    = proto_d;
    rec_o.sum         = sum_d;
    push_o            = byte_en_i && last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= ihc_pkg::LocalAddrReset;
    end else if (cfg_we_i) begin
      local_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      vihl_q  <= '0;
      total_q <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      match_q <= 1'b1;
      hold_q  <= '0;
    end else if (byte_en_i) begin
      if (last_i) begin
        pos_q   <= '0;
        sum_q   <= '0;
        vihl_q  <= '0;
        total_q <= '0;
        frag_q  <= '0;
        proto_q <= '0;
        match_q <= 1'b1;
        hold_q  <= '0;
      end else begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        vihl_q  <= vihl_d;
        total_q <= total_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        match_q <= match_d;
        hold_q  <= hold_d;
      end
    end
  end

endmodule

// ----- src/ihc_queue.sv -----
module ihc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ihc_pkg::frame_rec_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ihc_pkg::frame_rec_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ihc_pkg::frame_rec_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/ihc_back.sv -----
module ihc_back #(
  parameter int unsigned LINK_HEADER_BYTES = 14,
  parameter int unsigned COUNTER_BITS      = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  ihc_pkg::frame_rec_t rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ihc_pkg::result_t    out_o
);

  localparam logic [15:0] LinkBytes = 16'(LINK_HEADER_BYTES);
  localparam logic [16:0] MinFrame  = 17'(LINK_HEADER_BYTES + ihc_pkg::MinHeaderBytes);
  localparam logic [5:0]  MinHdr    = 6'(ihc_pkg::MinHeaderBytes);

  logic [COUNTER_BITS-1:0] cnt_q [5];
  logic [COUNTER_BITS-1:0] seen_q, seen_d;
  logic [COUNTER_BITS-1:0] cnt_new;
  logic [63:0]             cnt_wide, seen_wide;
  logic                    out_valid_q;
  ihc_pkg::result_t        out_q, res;

  logic             len_ok, bad_hdr, csum_ok, passed;
  logic [15:0]      avail, ihl16;
  logic [5:0]       ihl;
  logic [16:0]      fold1, fold2;
  logic [2:0]       cidx;
  ihc_pkg::verdict_e verdict;

  assign pop_o       = rec_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    len_ok  = ({1'b0, rec_i.len} >= MinFrame);
    avail   = rec_i.len - LinkBytes;
    ihl     = {rec_i.version_ihl[3:0], 2'b00};
    ihl16   = {10'b0, ihl};
    fold1   = 17'(rec_i.sum[15:0]) + 17'(rec_i.sum[16]);
    fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
    csum_ok = (fold2[15:0] == 16'hFFFF);
    bad_hdr = (rec_i.version_ihl[7:4] != ihc_pkg::IpVersion4) || (ihl < MinHdr) ||
              (ihl16 > avail) || (rec_i.total_len < ihl16) || (rec_i.total_len > avail);
    passed  = len_ok && !bad_hdr && csum_ok;

    priority if (!len_ok || bad_hdr) begin
      verdict = ihc_pkg::VerdictBadHeader;
    end else if (!csum_ok) begin
      verdict = ihc_pkg::VerdictBadCsum;
    end else if (rec_i.frag_hit) begin
      verdict = ihc_pkg::VerdictBadHeader;
    end else if (!rec_i.addr_match) begin
      verdict = ihc_pkg::VerdictNotOurs;
    end else if (rec_i.protocol == ihc_pkg::ProtoIcmp) begin
      verdict = ihc_pkg::VerdictIcmp;
    end else if (rec_i.protocol == ihc_pkg::ProtoUdp) begin
      verdict = ihc_pkg::VerdictUdp;
    end else begin
      verdict = ihc_pkg::VerdictNoHandler;
    end

    // both delivered verdicts share the first counter
    cidx = (verdict == ihc_pkg::VerdictIcmp || verdict == ihc_pkg::VerdictUdp) ?
           3'd0 : 3'(verdict) - 3'd1;
    cnt_new   = cnt_q[cidx] + COUNTER_BITS'(1);
    seen_d    = passed ? seen_q + COUNTER_BITS'(1) : seen_q;
    cnt_wide  = 64'(cnt_new);
    seen_wide = 64'(seen_d);

    res.verdict        = verdict;
    res.protocol       = len_ok ? rec_i.protocol : 8'd0;
    res.header_length  = len_ok ? ihl : 6'd0;
    res.payload_length = (verdict == ihc_pkg::VerdictIcmp || verdict == ihc_pkg::VerdictUdp) ?
                         rec_i.total_len - ihl16 : 16'd0;
    res.verdict_count  = cnt_wide[31:0];
    res.seen_count     = seen_wide[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      for (int i = 0; i < 5; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        seen_q      <= seen_d;
        cnt_q[cidx] <= cnt_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
